// File: design/apba_pkg.sv
// ----------------------------------------------------------------------------
// apba_pkg: shared definitions of the aligned pool bump allocator
// Widths, word layouts, register indexes, request kinds and status codes.
// ----------------------------------------------------------------------------
package apba_pkg;

   localparam int POOLS     = 4;
   localparam int POOL_W    = (POOLS > 1) ? $clog2(POOLS) : 1;
   localparam int SZ_W      = 36;
   localparam int AL_W      = 32;
   localparam int BASE_W    = 17;
   localparam int TYPE_W    = 5;
   localparam int TMASK_W   = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 36;
   localparam int CNT_W     = $clog2(SZ_W + 1);

   localparam int REQ_TDATA_W = 104;
   localparam int REQ_TUSER_W = 4;
   localparam int RSP_TDATA_W = 112;

   localparam logic [BASE_W-1:0] BASE_ALIGN_RESET = BASE_W'(64);

   typedef enum logic [2:0] {
      ST_OK            = 3'd0,
      ST_BAD_HANDLE    = 3'd1,
      ST_WRONG_KIND    = 3'd2,
      ST_ZERO_SIZE     = 3'd3,
      ST_TYPE_MISMATCH = 3'd4,
      ST_BAD_ALIGN     = 3'd5,
      ST_POOL_FULL     = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      KIND_IMAGE   = 2'd0,
      KIND_BUFFER  = 2'd1,
      KIND_TEXTURE = 2'd2,
      KIND_UNKNOWN = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_ALIGN  = 3'd0,
      CSR_POOL_SIZE_0 = 3'd1,
      CSR_POOL_SIZE_1 = 3'd2,
      CSR_POOL_SIZE_2 = 3'd3,
      CSR_POOL_SIZE_3 = 3'd4,
      CSR_POOL_DEVICE = 3'd5,
      CSR_DEVICE_TYPE = 3'd6,
      CSR_HOST_TYPE   = 3'd7
   } csr_index_type;

endpackage

// File: design/apba_div.sv
// ----------------------------------------------------------------------------
// apba_div: bit-serial remainder unit
// Restoring radix-2 division, one dividend bit per cycle; returns the
// remainder only. done pulses for one cycle when remainder is valid.
// ----------------------------------------------------------------------------
module apba_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [apba_pkg::SZ_W-1:0]  dividend,
   input  logic [apba_pkg::AL_W-1:0]  divisor,
   output logic                       done,
   output logic [apba_pkg::AL_W-1:0]  remainder
);

   logic [apba_pkg::SZ_W-1:0]  num_ff;
   logic [apba_pkg::AL_W-1:0]  rem_ff;
   logic [apba_pkg::AL_W-1:0]  den_ff;
   logic [apba_pkg::CNT_W-1:0] cnt_ff;
   logic                       busy_ff;
   logic                       done_ff;
   logic [apba_pkg::AL_W:0]    trial;
   logic [apba_pkg::AL_W:0]    diff;

   assign trial = {rem_ff, num_ff[apba_pkg::SZ_W-1]};
   assign diff  = trial - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            num_ff  <= dividend;
            den_ff  <= divisor;
            rem_ff  <= '0;
            cnt_ff  <= apba_pkg::CNT_W'(apba_pkg::SZ_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= diff[apba_pkg::AL_W] ? trial[apba_pkg::AL_W-1:0]
                                           : diff[apba_pkg::AL_W-1:0];
            num_ff <= {num_ff[apba_pkg::SZ_W-2:0], 1'b0};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == apba_pkg::CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// File: design/aligned_pool_bump_allocator_top.sv
// ----------------------------------------------------------------------------
// aligned_pool_bump_allocator_top: aligned per-pool bump allocator
// Checks a request, aligns size and pool offset with a shared bit-serial
// remainder unit, advances the pool offset and its high-water mark.
//
//  channel | dir | handshake          | payload
//  req     | in  | req_tvalid/tready  | req_tdata, req_tuser
//  rsp     | out | rsp_tvalid/tready  | rsp_tdata
//  csr     | in  | csr_valid/ready    | csr_index, csr_wdata
//
// A word that passes the early checks runs up to three remainders in turn
// (alignment check, size pad, offset pad), each with issue, load, one step per
// dividend bit and hand-back, then the range and fit checks and result load.
// A word rejected by the early checks goes straight to the result state.
// Synchronous reset clears every pool offset and mark at once.
// The result waits in an output register; the next word is taken in the
// cycle after it is loaded; a stall delays only the next result's load.
// ----------------------------------------------------------------------------
module aligned_pool_bump_allocator_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [0] handle_valid, [36:1] req_size, [68:37] req_alignment,
   // [100:69] req_type_mask, [103:101] zero
   input  logic [apba_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // [1:0] req_type, [3:2] pool_sel
   input  logic [apba_pkg::REQ_TUSER_W-1:0]    req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] ok, [3:1] status, [39:4] bound_offset, [75:40] bound_size,
   // [111:76] pool_high_water
   output logic [apba_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [apba_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [apba_pkg::CSR_DAT_W-1:0]      csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE, S_ALIGN, S_RANGE, S_SIZE, S_SPAD, S_OFF, S_OPAD, S_FIT, S_DONE
   } state_type;

   localparam int SZ_W = apba_pkg::SZ_W;
   localparam int AL_W = apba_pkg::AL_W;

   // configuration
   logic [apba_pkg::BASE_W-1:0] base_align_ff;
   logic [SZ_W-1:0]             pool_size_ff [apba_pkg::POOLS];
   logic [3:0]                  pool_device_ff;
   logic [apba_pkg::TYPE_W-1:0] device_type_ff;
   logic [apba_pkg::TYPE_W-1:0] host_type_ff;

   // pool state
   logic [SZ_W-1:0] pool_offset_ff [apba_pkg::POOLS];
   logic [SZ_W-1:0] pool_usage_ff  [apba_pkg::POOLS];

   // request fields
   logic [1:0]                   in_kind;
   logic [1:0]                   in_sel;
   logic                         in_handle;
   logic [SZ_W-1:0]              in_size;
   logic [AL_W-1:0]              in_align;
   logic [apba_pkg::TMASK_W-1:0] in_tmask;

   // early checks
   logic [apba_pkg::TYPE_W-1:0]  pool_type;
   logic [apba_pkg::TYPE_W-1:0]  check_type;
   logic [AL_W-1:0]              base_eff;
   logic [AL_W-1:0]              align_hi;
   logic [AL_W-1:0]              align_lo;
   apba_pkg::status_type         early_status;

   // working registers
   state_type                    state_ff;
   apba_pkg::status_type         status_ff;
   logic [apba_pkg::POOL_W-1:0]  idx_ff;
   logic                         in_range_ff;
   logic [SZ_W-1:0]              size_ff;
   logic [AL_W-1:0]              align_ff;
   logic [AL_W-1:0]              pad_ff;
   logic [SZ_W-1:0]              rsize_ff;
   logic [SZ_W-1:0]              off_ff;
   logic                         rsp_valid_ff;
   logic [apba_pkg::RSP_TDATA_W-1:0] rsp_data_ff;

   // divider
   logic                         div_start_ff;
   logic [SZ_W-1:0]              div_num_ff;
   logic [AL_W-1:0]              div_den_ff;
   logic                         div_done;
   logic [AL_W-1:0]              div_rem;
   logic [AL_W-1:0]              pad_val;

   logic [SZ_W-1:0]              cap;
   logic [SZ_W-1:0]              off_cur;
   logic [SZ_W-1:0]              new_off;
   logic                         ok_now;
   logic [SZ_W-1:0]              hw_now;

   assign in_kind   = req_tuser[1:0];
   assign in_sel    = req_tuser[3:2];
   assign in_handle = req_tdata[0];
   assign in_size   = req_tdata[36:1];
   assign in_align  = req_tdata[68:37];
   assign in_tmask  = req_tdata[100:69];

   assign pool_type  = pool_device_ff[in_sel] ? device_type_ff : host_type_ff;
   assign check_type = (in_kind == apba_pkg::KIND_IMAGE) ? device_type_ff : pool_type;
   assign base_eff   = (base_align_ff == '0) ? AL_W'(1) : AL_W'(base_align_ff);
   assign align_hi   = (in_align >= base_eff) ? in_align : base_eff;
   assign align_lo   = (in_align >= base_eff) ? base_eff : in_align;

   always_comb begin
      if (!in_handle) begin
         early_status = apba_pkg::ST_BAD_HANDLE;
      end else if (in_kind == apba_pkg::KIND_UNKNOWN) begin
         early_status = apba_pkg::ST_WRONG_KIND;
      end else if (in_kind == apba_pkg::KIND_TEXTURE && pool_type != device_type_ff) begin
         early_status = apba_pkg::ST_WRONG_KIND;
      end else if (in_size == '0) begin
         early_status = apba_pkg::ST_ZERO_SIZE;
      end else if (!in_tmask[check_type]) begin
         early_status = apba_pkg::ST_TYPE_MISMATCH;
      end else if (in_align == '0) begin
         early_status = apba_pkg::ST_BAD_ALIGN;
      end else begin
         early_status = apba_pkg::ST_OK;
      end
   end

   assign cap     = pool_size_ff[idx_ff];
   assign off_cur = pool_offset_ff[idx_ff];
   assign new_off = off_ff + rsize_ff;
   assign pad_val = (div_rem == '0) ? '0 : align_ff - div_rem;
   assign ok_now  = (status_ff == apba_pkg::ST_OK);
   assign hw_now  = in_range_ff ? pool_usage_ff[idx_ff] : '0;

   apba_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start_ff),
      .dividend  (div_num_ff),
      .divisor   (div_den_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         base_align_ff  <= apba_pkg::BASE_ALIGN_RESET;
         pool_device_ff <= '0;
         device_type_ff <= '0;
         host_type_ff   <= '0;
         for (int p = 0; p < apba_pkg::POOLS; p++) begin
            pool_size_ff[p] <= '0;
         end
      end else if (csr_valid) begin
         case (csr_index)
            apba_pkg::CSR_BASE_ALIGN:  base_align_ff  <= csr_wdata[apba_pkg::BASE_W-1:0];
            apba_pkg::CSR_POOL_DEVICE: pool_device_ff <= csr_wdata[3:0];
            apba_pkg::CSR_DEVICE_TYPE: device_type_ff <= csr_wdata[apba_pkg::TYPE_W-1:0];
            apba_pkg::CSR_HOST_TYPE:   host_type_ff   <= csr_wdata[apba_pkg::TYPE_W-1:0];
            default: begin
               for (int p = 0; p < apba_pkg::POOLS; p++) begin
                  if (32'(csr_index) == 32'(apba_pkg::CSR_POOL_SIZE_0) + p) begin
                     pool_size_ff[p] <= csr_wdata[SZ_W-1:0];
                  end
               end
            end
         endcase
      end
   end

   // request sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         div_start_ff <= 1'b0;
         for (int p = 0; p < apba_pkg::POOLS; p++) begin
            pool_offset_ff[p] <= '0;
            pool_usage_ff[p]  <= '0;
         end
      end else begin
         if (rsp_valid_ff && rsp_tready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  idx_ff      <= apba_pkg::POOL_W'(in_sel);
                  in_range_ff <= (32'(in_sel) < apba_pkg::POOLS);
                  size_ff     <= in_size;
                  align_ff    <= align_hi;
                  status_ff   <= early_status;
                  div_num_ff  <= SZ_W'(align_hi);
                  div_den_ff  <= align_lo;
                  if (early_status == apba_pkg::ST_OK) begin
                     div_start_ff <= 1'b1;
                     state_ff     <= S_ALIGN;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end
            end
            S_ALIGN: begin
               div_start_ff <= 1'b0;
               if (div_done) begin
                  if (div_rem != '0) begin
                     status_ff <= apba_pkg::ST_BAD_ALIGN;
                     state_ff  <= S_DONE;
                  end else begin
                     state_ff <= S_RANGE;
                  end
               end
            end
            S_RANGE: begin
               if (!in_range_ff || size_ff > cap || off_cur > cap) begin
                  status_ff <= apba_pkg::ST_POOL_FULL;
                  state_ff  <= S_DONE;
               end else begin
                  div_num_ff   <= size_ff;
                  div_den_ff   <= align_ff;
                  div_start_ff <= 1'b1;
                  state_ff     <= S_SIZE;
               end
            end
            S_SIZE: begin
               div_start_ff <= 1'b0;
               if (div_done) begin
                  pad_ff   <= pad_val;
                  state_ff <= S_SPAD;
               end
            end
            S_SPAD: begin
               if (SZ_W'(pad_ff) > cap - size_ff) begin
                  status_ff <= apba_pkg::ST_POOL_FULL;
                  state_ff  <= S_DONE;
               end else begin
                  rsize_ff     <= size_ff + SZ_W'(pad_ff);
                  div_num_ff   <= off_cur;
                  div_den_ff   <= align_ff;
                  div_start_ff <= 1'b1;
                  state_ff     <= S_OFF;
               end
            end
            S_OFF: begin
               div_start_ff <= 1'b0;
               if (div_done) begin
                  pad_ff   <= pad_val;
                  state_ff <= S_OPAD;
               end
            end
            S_OPAD: begin
               if (SZ_W'(pad_ff) > cap - off_cur) begin
                  status_ff <= apba_pkg::ST_POOL_FULL;
                  state_ff  <= S_DONE;
               end else begin
                  off_ff   <= off_cur + SZ_W'(pad_ff);
                  state_ff <= S_FIT;
               end
            end
            S_FIT: begin
               if (rsize_ff > cap - off_ff) begin
                  status_ff <= apba_pkg::ST_POOL_FULL;
               end else begin
                  pool_offset_ff[idx_ff] <= new_off;
                  if (new_off >= pool_usage_ff[idx_ff]) begin
                     pool_usage_ff[idx_ff] <= new_off;
                  end
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {hw_now,
                                   ok_now ? rsize_ff : {SZ_W{1'b0}},
                                   ok_now ? off_ff : {SZ_W{1'b0}},
                                   status_ff,
                                   ok_now};
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

endmodule

// File: tb/sv/aligned_pool_bump_allocator_top_tb.sv
// ----------------------------------------------------------------------------
// aligned_pool_bump_allocator_top_tb: self-checking bench for the allocator
// Drives allocation requests in random bursts under several register settings.
// The ledger class keeps its own pool offsets and high-water marks and checks
// every result word, field by field and in order. The output side stalls on
// its own patterns, once for long enough to back the block up.
// ----------------------------------------------------------------------------
typedef struct {
   apba_pkg::kind_type kind;
   bit [1:0]           pool;
   bit                 handle_ok;
   bit [35:0]          size;
   bit [31:0]          align;
   bit [31:0]          type_mask;
} alloc_request_type;

typedef struct {
   bit                   ok;
   apba_pkg::status_type status;
   bit [35:0]            offset;
   bit [35:0]            size;
   bit [35:0]            mark;
} grant_type;

class allocation_checker;
   bit [16:0]                base_align;
   bit [35:0]                pool_cap [apba_pkg::POOLS];
   bit [apba_pkg::POOLS-1:0] pool_device;
   bit [4:0]                 device_type;
   bit [4:0]                 host_type;
   bit [35:0]                pool_offset [apba_pkg::POOLS];
   bit [35:0]                pool_mark [apba_pkg::POOLS];
   grant_type                expected_grants [$];
   int unsigned              mismatches;
   int unsigned              granted;
   int unsigned              checked;

   function new();
      base_align = apba_pkg::BASE_ALIGN_RESET;
   endfunction

   function void set_register(apba_pkg::csr_index_type idx, bit [35:0] value);
      case (idx)
         apba_pkg::CSR_BASE_ALIGN:  base_align = value[16:0];
         apba_pkg::CSR_POOL_SIZE_0: pool_cap[0] = value;
         apba_pkg::CSR_POOL_SIZE_1: pool_cap[1] = value;
         apba_pkg::CSR_POOL_SIZE_2: pool_cap[2] = value;
         apba_pkg::CSR_POOL_SIZE_3: pool_cap[3] = value;
         apba_pkg::CSR_POOL_DEVICE: pool_device = value[3:0];
         apba_pkg::CSR_DEVICE_TYPE: device_type = value[4:0];
         apba_pkg::CSR_HOST_TYPE:   host_type = value[4:0];
         default: ;
      endcase
   endfunction

   function bit [63:0] pad_up(bit [63:0] v, bit [63:0] a);
      bit [63:0] r;
      r = v % a;
      return (r != 0) ? a - r : 64'd0;
   endfunction

   function apba_pkg::status_type judge(alloc_request_type r, output bit [63:0] start,
                                        output bit [63:0] span);
      bit [63:0] ptype, chk, base, a, lo, cap, off, size, spad, opad;
      start = 0;
      span  = 0;
      if (!r.handle_ok) return apba_pkg::ST_BAD_HANDLE;
      if (r.kind == apba_pkg::KIND_UNKNOWN) return apba_pkg::ST_WRONG_KIND;
      ptype = pool_device[r.pool] ? device_type : host_type;
      if (r.kind == apba_pkg::KIND_TEXTURE && ptype != device_type)
         return apba_pkg::ST_WRONG_KIND;
      if (r.size == 0) return apba_pkg::ST_ZERO_SIZE;
      chk = (r.kind == apba_pkg::KIND_IMAGE) ? device_type : ptype;
      if (!r.type_mask[chk[4:0]]) return apba_pkg::ST_TYPE_MISMATCH;
      if (r.align == 0) return apba_pkg::ST_BAD_ALIGN;
      base = (base_align == 0) ? 64'd1 : base_align;
      if (r.align >= base) begin
         a  = r.align;
         lo = base;
      end else begin
         a  = base;
         lo = r.align;
      end
      if (a % lo != 0) return apba_pkg::ST_BAD_ALIGN;
      cap  = pool_cap[r.pool];
      off  = pool_offset[r.pool];
      size = r.size;
      if (size > cap || off > cap) return apba_pkg::ST_POOL_FULL;
      spad = pad_up(size, a);
      if (spad > cap - size) return apba_pkg::ST_POOL_FULL;
      opad = pad_up(off, a);
      if (opad > cap - off) return apba_pkg::ST_POOL_FULL;
      if (size + spad > cap - off - opad) return apba_pkg::ST_POOL_FULL;
      start = off + opad;
      span  = size + spad;
      return apba_pkg::ST_OK;
   endfunction

   function void note_request(alloc_request_type r);
      grant_type g;
      bit [63:0] start, span;
      g.status = judge(r, start, span);
      g.ok     = (g.status == apba_pkg::ST_OK);
      if (g.ok) begin
         pool_offset[r.pool] = 36'(start + span);
         if (pool_offset[r.pool] >= pool_mark[r.pool])
            pool_mark[r.pool] = pool_offset[r.pool];
         granted++;
      end
      g.offset = 36'(start);
      g.size   = 36'(span);
      g.mark   = pool_mark[r.pool];
      expected_grants.push_back(g);
   endfunction

   task flag_mismatch(string what, bit [127:0] got, bit [127:0] want);
      $display("mismatch in %s at result %0d: got %0h, want %0h", what, checked, got, want);
      mismatches++;
   endtask

   task check_grant(bit [apba_pkg::RSP_TDATA_W-1:0] w);
      grant_type g;
      checked++;
      if (expected_grants.size() == 0) begin
         flag_mismatch("unrequested result word", w, 0);
         return;
      end
      g = expected_grants.pop_front();
      if (w[0] != g.ok)          flag_mismatch("ok", w[0], g.ok);
      if (w[3:1] != g.status)    flag_mismatch("status", w[3:1], g.status);
      if (w[39:4] != g.offset)   flag_mismatch("bound_offset", w[39:4], g.offset);
      if (w[75:40] != g.size)    flag_mismatch("bound_size", w[75:40], g.size);
      if (w[111:76] != g.mark)   flag_mismatch("pool_high_water", w[111:76], g.mark);
   endtask
endclass

module aligned_pool_bump_allocator_top_tb;

   localparam bit [35:0] SZ_MAX  = '1;
   localparam bit [31:0] ALL_ONE = '1;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [apba_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic [apba_pkg::REQ_TUSER_W-1:0] req_tuser = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [apba_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [apba_pkg::CSR_IDX_W-1:0]   csr_index = apba_pkg::CSR_BASE_ALIGN;
   logic [apba_pkg::CSR_DAT_W-1:0]   csr_wdata = '0;

   allocation_checker ledger = new();
   alloc_request_type pending_requests [$];
   alloc_request_type req_cur;
   int unsigned       n_accepted = 0;
   int unsigned       n_settings = 1;
   int unsigned       burst_left = 0;
   int unsigned       gap_left = 0;
   int unsigned       rsp_mode = 0;
   int unsigned       rsp_mode_left = 0;
   int unsigned       rsp_period = 2;
   int unsigned       rsp_tick = 0;
   logic              hold_off = 1'b0;

   aligned_pool_bump_allocator_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // request side: bursts of words, random gaps
   always @(posedge clock) begin : req_driver
      bit offer;
      offer = req_tvalid && !req_tready;
      if (req_tvalid && req_tready) begin
         ledger.note_request(req_cur);
         n_accepted++;
         if (burst_left != 0) burst_left--;
      end
      if (!offer && !reset) begin
         if (burst_left == 0) begin
            if (gap_left != 0) gap_left--;
            else begin
               burst_left = $urandom_range(1, 48);
               gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 180)
                                                      : $urandom_range(0, 5);
            end
         end
         if (burst_left != 0 && pending_requests.size() != 0) begin
            req_cur = pending_requests.pop_front();
            req_tdata <= {3'b000, req_cur.type_mask, req_cur.align, req_cur.size,
                          req_cur.handle_ok};
            req_tuser <= {req_cur.pool, req_cur.kind};
            offer = 1'b1;
         end
      end
      req_tvalid <= offer;
   end

   // result side stall patterns
   always @(posedge clock) begin : rsp_pacing
      bit ready_next;
      if (rsp_mode_left == 0) begin
         rsp_mode      = $urandom_range(0, 3);
         rsp_mode_left = $urandom_range(20, 400);
         rsp_period    = $urandom_range(2, 9);
      end else begin
         rsp_mode_left--;
      end
      rsp_tick++;
      case (rsp_mode)
         0:       ready_next = 1'b1;
         1:       ready_next = ($urandom_range(0, 1) == 1);
         2:       ready_next = (rsp_tick % rsp_period) == 0;
         default: ready_next = ($urandom_range(0, 7) != 0);
      endcase
      rsp_tready <= ready_next && !hold_off;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) ledger.check_grant(rsp_tdata);
   end

   // long hold-off on the result side so the block backs up
   initial begin : back_pressure
      wait (n_accepted >= 400);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (1500) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin
      #8000000;
      $display("simulation failed");
      $finish;
   end

   function automatic void add_request(apba_pkg::kind_type kind, bit [1:0] pool, bit hv,
                                       bit [35:0] size, bit [31:0] align,
                                       bit [31:0] mask);
      alloc_request_type r;
      r.kind      = kind;
      r.pool      = pool;
      r.handle_ok = hv;
      r.size      = size;
      r.align     = align;
      r.type_mask = mask;
      pending_requests.push_back(r);
   endfunction

   function automatic bit [35:0] pick_capacity();
      case ($urandom_range(0, 5))
         0:       return 36'd0;
         1:       return {4'($urandom), 32'($urandom)};
         2:       return 36'(1) << $urandom_range(12, 35);
         default: return SZ_MAX;
      endcase
   endfunction

   function automatic alloc_request_type random_request();
      alloc_request_type r;
      bit [31:0]         base;
      base   = (ledger.base_align == 0) ? 32'd1 : 32'(ledger.base_align);
      r.pool = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 19) < 17) begin
         r.kind      = apba_pkg::kind_type'($urandom_range(0, 2));
         r.handle_ok = 1'b1;
         case ($urandom_range(0, 39))
            0:       r.size = {4'($urandom), 32'($urandom)};
            1:       r.size = 36'(1) << $urandom_range(20, 35);
            2, 3, 4: r.size = 36'($urandom_range(1, 1 << 20));
            default: r.size = 36'($urandom_range(1, 4096));
         endcase
         case ($urandom_range(0, 19))
            0:          r.align = 32'(1) << $urandom_range(17, 31);
            1, 2, 3:    r.align = base * $urandom_range(1, 4);
            4, 5:       r.align = base;
            6:          r.align = 32'd1;
            default:    r.align = 32'(1) << $urandom_range(0, 16);
         endcase
         r.type_mask = $urandom | (32'(1) << ledger.device_type)
                                | (32'(1) << ledger.host_type);
      end else begin
         r.kind      = apba_pkg::kind_type'($urandom_range(0, 3));
         r.handle_ok = 1'($urandom_range(0, 1));
         r.size      = ($urandom_range(0, 7) == 0) ? 36'd0 : {4'($urandom), 32'($urandom)};
         r.align     = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom;
         r.type_mask = $urandom;
      end
      return r;
   endfunction

   // settled state is looked at mid-cycle, then control returns on a rising edge
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_tvalid ||
             ledger.expected_grants.size() != 0);
      @(posedge clock);
   endtask

   task automatic program_registers(input bit [35:0] regs [8]);
      for (int i = 0; i < 8; i++) begin
         csr_index <= apba_pkg::csr_index_type'(i);
         csr_wdata <= regs[i];
         csr_valid <= 1'b1;
         do @(posedge clock); while (!csr_ready);
         ledger.set_register(apba_pkg::csr_index_type'(i), regs[i]);
      end
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   task automatic run_phase(input bit [35:0] regs [8], input int unsigned items);
      program_registers(regs);
      repeat (items) pending_requests.push_back(random_request());
      wait_idle();
   endtask

   initial begin : stimulus
      bit [35:0] cfg [8];
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: every pool empty
      add_request(apba_pkg::KIND_BUFFER, 0, 0, 100, 64, ALL_ONE);
      add_request(apba_pkg::KIND_IMAGE, 1, 1, 64, 64, 32'd1);
      add_request(apba_pkg::KIND_TEXTURE, 2, 1, 1, 0, ALL_ONE);
      add_request(apba_pkg::KIND_UNKNOWN, 3, 1, 8, 64, ALL_ONE);
      wait_idle();

      // pools 0 and 2 device-local (type 3), 1 and 3 host (type 17)
      cfg = '{36'd64, 36'd4096, SZ_MAX, 36'(1) << 20, 36'd0, 36'b0101, 36'd3, 36'd17};
      program_registers(cfg);
      add_request(apba_pkg::KIND_BUFFER, 0, 0, 100, 64, ALL_ONE);
      add_request(apba_pkg::KIND_UNKNOWN, 1, 1, 100, 64, ALL_ONE);
      add_request(apba_pkg::KIND_TEXTURE, 1, 1, 100, 64, ALL_ONE);
      add_request(apba_pkg::KIND_TEXTURE, 0, 1, 100, 64, ALL_ONE);
      add_request(apba_pkg::KIND_BUFFER, 1, 1, 0, 64, ALL_ONE);
      add_request(apba_pkg::KIND_BUFFER, 1, 1, 100, 64, ~(32'(1) << 17));
      add_request(apba_pkg::KIND_IMAGE, 1, 1, 1, 64, 32'(1) << 3);
      add_request(apba_pkg::KIND_BUFFER, 1, 1, 10, 0, 32'(1) << 17);
      add_request(apba_pkg::KIND_BUFFER, 1, 1, 10, 96, ALL_ONE);
      add_request(apba_pkg::KIND_BUFFER, 1, 1, 10, ALL_ONE, ALL_ONE);
      add_request(apba_pkg::KIND_BUFFER, 2, 1, 10, 16, 32'(1) << 3);
      add_request(apba_pkg::KIND_BUFFER, 1, 1, 1, 32'h8000_0000, ALL_ONE);
      add_request(apba_pkg::KIND_BUFFER, 1, 1, SZ_MAX, 64, ALL_ONE);
      add_request(apba_pkg::KIND_BUFFER, 1, 1, 36'h8_0000_0001, 1, ALL_ONE);
      add_request(apba_pkg::KIND_BUFFER, 3, 1, 1, 64, ALL_ONE);
      add_request(apba_pkg::KIND_BUFFER, 0, 1, 4096, 64, ALL_ONE);
      add_request(apba_pkg::KIND_BUFFER, 0, 1, 3968, 64, ALL_ONE);
      add_request(apba_pkg::KIND_BUFFER, 0, 1, 1, 64, ALL_ONE);
      add_request(apba_pkg::KIND_IMAGE, 2, 1, 10, 64, 32'd0);
      add_request(apba_pkg::KIND_TEXTURE, 2, 1, 4097, 4096, ALL_ONE);
      wait_idle();

      cfg = '{36'd1, SZ_MAX, SZ_MAX, SZ_MAX, SZ_MAX, 36'b1111, 36'd31, 36'd0};
      run_phase(cfg, 240);
      cfg = '{36'd65536, SZ_MAX, pick_capacity(), 36'(1) << 30, SZ_MAX, 36'd0, 36'd0, 36'd31};
      run_phase(cfg, 240);
      // zero base behaves as one
      cfg = '{36'd0, pick_capacity(), pick_capacity(), pick_capacity(), pick_capacity(),
              36'($urandom_range(0, 15)), 36'($urandom_range(0, 31)),
              36'($urandom_range(0, 31))};
      run_phase(cfg, 240);
      cfg = '{36'd48, SZ_MAX, pick_capacity(), pick_capacity(), SZ_MAX,
              36'($urandom_range(0, 15)), 36'd5, 36'($urandom_range(0, 1) ? 5 : 9)};
      run_phase(cfg, 240);
      cfg = '{36'($urandom_range(1, 65536)), pick_capacity(), pick_capacity(),
              pick_capacity(), pick_capacity(), 36'($urandom_range(0, 15)),
              36'($urandom_range(0, 31)), 36'($urandom_range(0, 31))};
      run_phase(cfg, 240);
      // capacities dropped under the offsets already handed out
      cfg = '{36'd64, 36'($urandom_range(0, 2000)), 36'($urandom_range(0, 2000)),
              36'($urandom_range(0, 2000)), 36'($urandom_range(0, 2000)),
              36'($urandom_range(0, 15)), 36'($urandom_range(0, 31)),
              36'($urandom_range(0, 31))};
      run_phase(cfg, 160);

      repeat (200) @(posedge clock);
      $display("%0d requests taken, %0d granted, %0d result words checked",
               n_accepted, ledger.granted, ledger.checked);
      $display("%0d register settings incl. reset, alignment extremes, shrunken pools",
               n_settings);
      if (ledger.mismatches == 0 && ledger.expected_grants.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
